FILE: hdl/pinned_lru_page_table_defines.svh
// Assertion macros shared by the page table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PINNED_LRU_PAGE_TABLE_DEFINES_SVH
`define PINNED_LRU_PAGE_TABLE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PLT_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle where the condition is true.
`define PLT_ASSERT_WHEN(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

FILE: hdl/plt_pkg.sv
// Types and codes of the pinned LRU page table.
// Depends on nothing; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    // Operation codes of a request.
    localparam logic [2:0] OP_LOCK         = 3'd0;
    localparam logic [2:0] OP_UNLOCK       = 3'd1;
    localparam logic [2:0] OP_MARK_DIRTY   = 3'd2;
    localparam logic [2:0] OP_MARK_VALID   = 3'd3;
    localparam logic [2:0] OP_WRITTEN_BACK = 3'd4;

    // Status codes of a response.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL    = 3'd1;
    localparam logic [2:0] ST_NOT_PRESENT   = 3'd2;
    localparam logic [2:0] ST_LOCK_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_NOT_LOCKED    = 3'd4;

    localparam int PAGE_W = 31;
    localparam int OP_W   = 3;

    // Command broadcast to the row of cells.
    typedef enum logic [3:0] {
        CELL_NOP,
        CELL_MATCH,
        CELL_CREATE,
        CELL_TO_FRONT,
        CELL_LOCK_INC,
        CELL_UNLOCK_DEC,
        CELL_DROP_CLEAN,
        CELL_DROP_DIRTY,
        CELL_MARK_DIRTY,
        CELL_MARK_VALID,
        CELL_WRITE_BACK,
        CELL_EVICT
    } t_cell_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_APPLY,
        S_EVICT,
        S_DONE
    } t_state;

    // Flags a cell reports to the sequencer.
    typedef struct packed {
        logic hit;
        logic first_free;
        logic hit_dirty;
        logic hit_valid;
        logic tail;
    } t_cell_flags;

endpackage

`default_nettype wire

FILE: hdl/plt_if.sv
// Handshake channels of the page table: request, response and configuration.
// Depends on plt_pkg for the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plt_req_if;
    logic                       valid;
    logic                       ready;
    logic [plt_pkg::OP_W-1:0]   operation;
    logic [plt_pkg::PAGE_W-1:0] page_index;
    modport source (output valid, operation, page_index, input ready);
    modport sink (input valid, operation, page_index, output ready);
endinterface

interface plt_rsp_if #(
    parameter int SLOT_W = 6,
    parameter int CNT_W  = 7,
    parameter int LOCK_W = 8
);
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              start_transfer;
    logic              cancel_transfer;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  evicted_count;
    logic [LOCK_W-1:0] lock_count;
    modport source (output valid, status, start_transfer, cancel_transfer, slot,
                    evicted_count, lock_count, input ready);
    modport sink (input valid, status, start_transfer, cancel_transfer, slot,
                  evicted_count, lock_count, output ready);
endinterface

interface plt_cfg_if #(
    parameter int CNT_W = 7
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] page_limit;
    modport source (output valid, page_limit, input ready);
    modport sink (input valid, page_limit, output ready);
endinterface

`default_nettype wire

FILE: hdl/plt_cell.sv
// One slot of the page table: tag, lock count, marks and recency rank.
// Depends on plt_pkg; instantiated in a row by pinned_lru_page_table.
`timescale 1ns / 1ps
`default_nettype none

module plt_cell #(
    parameter int SLOT_W = 6,
    parameter int LOCK_W = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  plt_pkg::t_cell_op      i_cmd,
    input  wire                          i_sel,
    input  wire  [plt_pkg::PAGE_W-1:0]   i_page,
    input  wire  [SLOT_W-1:0]            i_rank,
    input  wire  [SLOT_W-1:0]            i_tail_rank,
    input  wire                          i_free_in,
    output logic                         o_free_out,
    output plt_pkg::t_cell_flags         o_flags,
    output logic [LOCK_W-1:0]            o_hit_locks,
    output logic [LOCK_W-1:0]            o_tail_locks,
    output logic [SLOT_W-1:0]            o_hit_rank
);

    logic                       r_in_use;
    logic                       r_hit;
    logic                       r_first_free;
    logic [plt_pkg::PAGE_W-1:0] r_page;
    logic [LOCK_W-1:0]          r_locks;
    logic                       r_valid;
    logic                       r_dirty;
    logic [SLOT_W-1:0]          r_rank;
    logic                       w_clean;
    logic                       w_tail;

    assign w_clean = r_in_use && !r_dirty;
    assign w_tail  = w_clean && (r_rank == i_tail_rank);

    // A free slot is passed down the row so only the lowest one claims it.
    assign o_free_out = i_free_in || !r_in_use;

    // Flags and values seen by the sequencer.
    always_comb begin
        o_flags.hit        = r_hit;
        o_flags.first_free = r_first_free;
        o_flags.hit_dirty  = r_hit && r_dirty;
        o_flags.hit_valid  = r_hit && r_valid;
        o_flags.tail       = w_tail;
        o_hit_locks        = r_hit ? r_locks : '0;
        o_tail_locks       = w_tail ? r_locks : '0;
        o_hit_rank         = r_hit ? r_rank : '0;
    end

    // Control bits of the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= 1'b0;
            r_hit        <= 1'b0;
            r_first_free <= 1'b0;
        end else begin
            unique case (i_cmd)
                plt_pkg::CELL_MATCH: begin
                    r_hit        <= r_in_use && (r_page == i_page);
                    r_first_free <= !r_in_use && !i_free_in;
                end
                plt_pkg::CELL_CREATE: begin
                    if (i_sel) r_in_use <= 1'b1;
                end
                plt_pkg::CELL_DROP_CLEAN, plt_pkg::CELL_DROP_DIRTY,
                plt_pkg::CELL_EVICT: begin
                    if (i_sel) r_in_use <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Slot contents and recency rank.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            plt_pkg::CELL_CREATE: begin
                if (i_sel) begin
                    r_page  <= i_page;
                    r_locks <= LOCK_W'(1);
                    r_valid <= 1'b0;
                    r_dirty <= 1'b0;
                    r_rank  <= '0;
                end else if (w_clean) begin
                    r_rank <= r_rank + SLOT_W'(1);
                end
            end
            plt_pkg::CELL_TO_FRONT: begin
                if (i_sel) begin
                    r_rank  <= '0;
                    r_locks <= r_locks + LOCK_W'(1);
                end else if (w_clean && r_rank < i_rank) begin
                    r_rank <= r_rank + SLOT_W'(1);
                end
            end
            plt_pkg::CELL_LOCK_INC: begin
                if (i_sel) r_locks <= r_locks + LOCK_W'(1);
            end
            plt_pkg::CELL_UNLOCK_DEC: begin
                if (i_sel) r_locks <= r_locks - LOCK_W'(1);
            end
            plt_pkg::CELL_DROP_CLEAN, plt_pkg::CELL_MARK_DIRTY: begin
                if (i_sel) begin
                    if (i_cmd == plt_pkg::CELL_MARK_DIRTY) r_dirty <= 1'b1;
                end else if (w_clean && r_rank > i_rank) begin
                    r_rank <= r_rank - SLOT_W'(1);
                end
            end
            plt_pkg::CELL_MARK_VALID: begin
                if (i_sel) r_valid <= 1'b1;
            end
            plt_pkg::CELL_WRITE_BACK: begin
                if (i_sel) begin
                    r_dirty <= 1'b0;
                    r_rank  <= '0;
                end else if (w_clean) begin
                    r_rank <= r_rank + SLOT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/pinned_lru_page_table.sv
// Top level of the pinned LRU page table: sequencer and the row of slot cells.
// Depends on plt_pkg, plt_if, plt_cell and pinned_lru_page_table_defines.svh.
//
// Use: a request on i_req carries an operation and a page number. Exactly one
// response follows on o_rsp with status, transfer start or cancel, the slot,
// the number of evicted pages and the resulting lock count. i_cfg writes the
// clean page limit; it is to be written only while the block is idle, which
// the block itself does not enforce. i_cfg is always ready.
// Sequence: once the request is taken the sequencer passes through search,
// decide and apply, then offers the response. A lock or unlock that succeeds
// adds an eviction step before the response, which walks the eviction one
// page per cycle through the cell row.
// Requests are handled one at a time; a new one is taken only after the
// response has been accepted and the sequencer is back in idle.
// i_req.ready is high only while idle.
// Reset clears every slot's in-use mark, the clean count and sets the limit
// to SLOTS; no clearing pass is needed.
// A stalled receiver holds the response in its registers; no new request is
// taken until the response has been accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "pinned_lru_page_table_defines.svh"

module pinned_lru_page_table #(
    parameter int SLOTS     = 64,
    parameter int LOCK_BITS = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    plt_req_if.sink   i_req,
    plt_rsp_if.source o_rsp,
    plt_cfg_if.sink   i_cfg
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = LOCK_BITS;
    localparam logic [LW-1:0] LOCK_MAX = {LW{1'b1}};

    plt_pkg::t_state            r_state;
    plt_pkg::t_state            n_state;
    logic [plt_pkg::OP_W-1:0]   r_op;
    logic [plt_pkg::PAGE_W-1:0] r_page;
    logic [CW-1:0]              r_limit;
    logic [CW-1:0]              r_clean;
    logic [CW-1:0]              n_clean;
    plt_pkg::t_cell_op          r_cmd;
    plt_pkg::t_cell_op          n_cmd;
    logic [SW-1:0]              r_sel;
    logic [SW-1:0]              n_sel;
    logic [SW-1:0]              r_rank;
    logic                       r_do_evict;
    logic                       n_do_evict;
    logic [2:0]                 r_status;
    logic [2:0]                 n_status;
    logic                       r_start;
    logic                       n_start;
    logic                       r_cancel;
    logic                       n_cancel;
    logic [SW-1:0]              r_slot;
    logic [SW-1:0]              n_slot;
    logic [CW-1:0]              r_evicted;
    logic [LW-1:0]              r_locks;
    logic [LW-1:0]              n_locks;

    plt_pkg::t_cell_op          w_cmd;
    logic [SLOTS-1:0]           w_sel;
    logic [SLOTS:0]             w_free;
    logic [SW-1:0]              w_tail_rank;
    plt_pkg::t_cell_flags       w_flags [SLOTS];
    logic [LW-1:0]              w_hit_locks [SLOTS];
    logic [LW-1:0]              w_tail_locks [SLOTS];
    logic [SW-1:0]              w_hit_rank [SLOTS];
    logic [SLOTS-1:0]           w_hit_vec;
    logic [SLOTS-1:0]           w_tail_vec;

    logic                       g_hit;
    logic                       g_free;
    logic                       g_dirty;
    logic                       g_valid;
    logic                       g_tail;
    logic [SW-1:0]              g_hit_idx;
    logic [SW-1:0]              g_free_idx;
    logic [SW-1:0]              g_rank;
    logic [LW-1:0]              g_locks;
    logic [LW-1:0]              g_tail_locks;
    logic                       w_evict_go;

    assign w_tail_rank = SW'(r_clean - CW'(1));
    assign w_free[0]   = 1'b0;

    // Row of slot cells; the free-slot chain runs from slot 0 upward.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign w_sel[g] = (r_state == plt_pkg::S_EVICT) ? w_flags[g].tail
                                                        : (r_sel == SW'(g));
        assign w_hit_vec[g]  = w_flags[g].hit;
        assign w_tail_vec[g] = w_flags[g].tail;
        plt_cell #(
            .SLOT_W (SW),
            .LOCK_W (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (w_sel[g]),
            .i_page       (r_page),
            .i_rank       (r_rank),
            .i_tail_rank  (w_tail_rank),
            .i_free_in    (w_free[g]),
            .o_free_out   (w_free[g+1]),
            .o_flags      (w_flags[g]),
            .o_hit_locks  (w_hit_locks[g]),
            .o_tail_locks (w_tail_locks[g]),
            .o_hit_rank   (w_hit_rank[g])
        );
    end

    // Gather what the cells report; at most one cell hits and one is first free.
    always_comb begin
        g_hit        = 1'b0;
        g_free       = 1'b0;
        g_dirty      = 1'b0;
        g_valid      = 1'b0;
        g_tail       = 1'b0;
        g_hit_idx    = '0;
        g_free_idx   = '0;
        g_rank       = '0;
        g_locks      = '0;
        g_tail_locks = '0;
        for (int i = 0; i < SLOTS; i++) begin
            g_hit        = g_hit | w_flags[i].hit;
            g_free       = g_free | w_flags[i].first_free;
            g_dirty      = g_dirty | w_flags[i].hit_dirty;
            g_valid      = g_valid | w_flags[i].hit_valid;
            g_tail       = g_tail | w_flags[i].tail;
            g_hit_idx    = g_hit_idx | (w_flags[i].hit ? SW'(i) : '0);
            g_free_idx   = g_free_idx | (w_flags[i].first_free ? SW'(i) : '0);
            g_rank       = g_rank | w_hit_rank[i];
            g_locks      = g_locks | w_hit_locks[i];
            g_tail_locks = g_tail_locks | w_tail_locks[i];
        end
    end

    // Eviction continues while too many clean pages remain and the tail is unlocked.
    assign w_evict_go = (r_clean > r_limit) && g_tail && (g_tail_locks == '0);

    // Decision on the request once the search result is known.
    always_comb begin
        n_status   = plt_pkg::ST_OK;
        n_start    = 1'b0;
        n_cancel   = 1'b0;
        n_slot     = '0;
        n_locks    = '0;
        n_cmd      = plt_pkg::CELL_NOP;
        n_sel      = g_hit_idx;
        n_do_evict = 1'b0;
        n_clean    = r_clean;
        unique case (r_op)
            plt_pkg::OP_LOCK: begin
                if (g_hit) begin
                    n_slot = g_hit_idx;
                    if (g_locks == LOCK_MAX) begin
                        n_status = plt_pkg::ST_LOCK_OVERFLOW;
                        n_locks  = g_locks;
                    end else begin
                        n_cmd      = g_dirty ? plt_pkg::CELL_LOCK_INC
                                             : plt_pkg::CELL_TO_FRONT;
                        n_locks    = g_locks + LW'(1);
                        n_do_evict = 1'b1;
                    end
                end else if (g_free) begin
                    n_cmd      = plt_pkg::CELL_CREATE;
                    n_sel      = g_free_idx;
                    n_slot     = g_free_idx;
                    n_locks    = LW'(1);
                    n_start    = 1'b1;
                    n_clean    = r_clean + CW'(1);
                    n_do_evict = 1'b1;
                end else begin
                    n_status = plt_pkg::ST_TABLE_FULL;
                end
            end
            plt_pkg::OP_UNLOCK, plt_pkg::OP_MARK_DIRTY, plt_pkg::OP_MARK_VALID,
            plt_pkg::OP_WRITTEN_BACK: begin
                if (!g_hit) begin
                    n_status = plt_pkg::ST_NOT_PRESENT;
                end else begin
                    n_slot  = g_hit_idx;
                    n_locks = g_locks;
                    if (r_op == plt_pkg::OP_UNLOCK) begin
                        if (g_locks == '0) begin
                            n_status = plt_pkg::ST_NOT_LOCKED;
                        end else begin
                            n_do_evict = 1'b1;
                            if (g_locks == LW'(1) && !g_valid) begin
                                n_cmd    = g_dirty ? plt_pkg::CELL_DROP_DIRTY
                                                   : plt_pkg::CELL_DROP_CLEAN;
                                n_cancel = 1'b1;
                                n_locks  = '0;
                                if (!g_dirty) n_clean = r_clean - CW'(1);
                            end else begin
                                n_cmd   = plt_pkg::CELL_UNLOCK_DEC;
                                n_locks = g_locks - LW'(1);
                            end
                        end
                    end else if (r_op == plt_pkg::OP_MARK_DIRTY) begin
                        if (!g_dirty) begin
                            n_cmd   = plt_pkg::CELL_MARK_DIRTY;
                            n_clean = r_clean - CW'(1);
                        end
                    end else if (r_op == plt_pkg::OP_MARK_VALID) begin
                        n_cmd = plt_pkg::CELL_MARK_VALID;
                    end else if (g_dirty) begin
                        n_cmd   = plt_pkg::CELL_WRITE_BACK;
                        n_clean = r_clean + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plt_pkg::S_IDLE:   if (i_req.valid) n_state = plt_pkg::S_SEARCH;
            plt_pkg::S_SEARCH: n_state = plt_pkg::S_DECIDE;
            plt_pkg::S_DECIDE: n_state = plt_pkg::S_APPLY;
            plt_pkg::S_APPLY:  n_state = r_do_evict ? plt_pkg::S_EVICT
                                                    : plt_pkg::S_DONE;
            plt_pkg::S_EVICT:  if (!w_evict_go) n_state = plt_pkg::S_DONE;
            plt_pkg::S_DONE:   if (o_rsp.ready) n_state = plt_pkg::S_IDLE;
            default:           n_state = plt_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer and the command seen by the cells.
    always_comb begin
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        w_cmd       = plt_pkg::CELL_NOP;
        unique case (r_state)
            plt_pkg::S_IDLE:   i_req.ready = 1'b1;
            plt_pkg::S_SEARCH: w_cmd = plt_pkg::CELL_MATCH;
            plt_pkg::S_APPLY:  w_cmd = r_cmd;
            plt_pkg::S_EVICT:  if (w_evict_go) w_cmd = plt_pkg::CELL_EVICT;
            plt_pkg::S_DONE:   o_rsp.valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign i_cfg.ready           = 1'b1;
    assign o_rsp.status          = r_status;
    assign o_rsp.start_transfer  = r_start;
    assign o_rsp.cancel_transfer = r_cancel;
    assign o_rsp.slot            = r_slot;
    assign o_rsp.evicted_count   = r_evicted;
    assign o_rsp.lock_count      = r_locks;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::S_IDLE;
            r_limit <= CW'(SLOTS);
            r_clean <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_limit <= i_cfg.page_limit;
            if (r_state == plt_pkg::S_DECIDE) begin
                r_clean <= n_clean;
            end else if (r_state == plt_pkg::S_EVICT && w_evict_go) begin
                r_clean <= r_clean - CW'(1);
            end
        end
    end

    // Request and result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == plt_pkg::S_IDLE && i_req.valid) begin
            r_op      <= i_req.operation;
            r_page    <= i_req.page_index;
            r_evicted <= '0;
        end
        if (r_state == plt_pkg::S_DECIDE) begin
            r_status   <= n_status;
            r_start    <= n_start;
            r_cancel   <= n_cancel;
            r_slot     <= n_slot;
            r_locks    <= n_locks;
            r_cmd      <= n_cmd;
            r_sel      <= n_sel;
            r_rank     <= g_rank;
            r_do_evict <= n_do_evict;
        end
        if (r_state == plt_pkg::S_EVICT && w_evict_go) begin
            r_evicted <= r_evicted + CW'(1);
        end
    end

    // Checks on the sequencer and the cell row.
    `PLT_ASSERT_ALWAYS(a_clean_bound, i_clk, i_rst_n, r_clean <= CW'(SLOTS), "clean count exceeds slots")
    `PLT_ASSERT_WHEN(a_single_hit, i_clk, i_rst_n, r_state == plt_pkg::S_DECIDE, $onehot0(w_hit_vec), "page found in more than one slot")
    `PLT_ASSERT_WHEN(a_single_tail, i_clk, i_rst_n, r_state == plt_pkg::S_EVICT, $onehot0(w_tail_vec), "more than one least recent page")
    `PLT_ASSERT_WHEN(a_transfer_excl, i_clk, i_rst_n, r_state == plt_pkg::S_DONE, !(r_start && r_cancel), "transfer started and cancelled together")

endmodule

`default_nettype wire
